// ----- rtl/gwm_pkg.sv -----
package gwm_pkg;

   // Configuration register index and the register map.
   typedef logic [2:0] csr_idx_type;

   localparam csr_idx_type CSR_WORD0  = 3'd0;
   localparam csr_idx_type CSR_WORD1  = 3'd1;
   localparam csr_idx_type CSR_WORD2  = 3'd2;
   localparam csr_idx_type CSR_WORD3  = 3'd3;
   localparam csr_idx_type CSR_LENGTH = 3'd4;

   // Pattern words in order; word k holds pattern characters 8k to 8k+7.
   localparam int          CSR_WORDS = 4;
   localparam csr_idx_type CSR_WORD_IDX [CSR_WORDS] = '{CSR_WORD0, CSR_WORD1,
                                                        CSR_WORD2, CSR_WORD3};

   localparam int CSR_DATA_W  = 64;
   localparam int LENGTH_W    = 6;
   localparam int CHARS_PER_W = CSR_DATA_W / 8;

   // Input item kinds.
   localparam logic KIND_TEXT = 1'b0;
   localparam logic KIND_END  = 1'b1;

   // Wildcard characters.
   localparam logic [7:0] WILD_ONE = 8'h3F;
   localparam logic [7:0] WILD_RUN = 8'h2A;

   // ASCII case folding: only A-Z map to a-z.
   function automatic logic [7:0] fold_char(input logic [7:0] c);
      logic [7:0] r;
      r = c;
      if (c >= 8'h41 && c <= 8'h5A) begin
         r = c + 8'h20;
      end
      return r;
   endfunction

endpackage

// ----- rtl/glob_wildcard_matcher_top.sv -----
// Latency: a result appears in the cycle after its end-of-string transaction is accepted.
// Throughput: one input transaction per cycle; the position vector updates in one step.
// The result register stalls the input only while an unread result is held and not taken.
// Reset (synchronous, active high): pattern registers cleared, position vector set to
// the start position, no result pending.
module glob_wildcard_matcher_top #(
   parameter int PATTERN_CHARS = 32
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic                             req_kind,
   input  logic [7:0]                       req_text_char,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic                             rsp_matched,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  gwm_pkg::csr_idx_type             csr_index,
   input  logic [gwm_pkg::CSR_DATA_W-1:0]   csr_data
);
   import gwm_pkg::*;

   localparam int N  = PATTERN_CHARS;
   localparam int LW = $clog2(N + 1);

   logic [N-1:0][7:0] pattern;
   logic [LW-1:0]     used_len;
   logic [N:0]        active_ff;
   logic [N:0]        active_in;
   logic [N:0]        next_pos;
   logic              step_matched;
   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   logic              rsp_matched_ff;
   logic              rsp_matched_in;
   logic              req_fire;

   gwm_cfg #(.PATTERN_CHARS(N)) u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .pattern   (pattern),
      .used_len  (used_len)
   );

   gwm_step #(.PATTERN_CHARS(N)) u_step (
      .cur_raw   (active_ff),
      .pattern   (pattern),
      .used_len  (used_len),
      .text_char (req_text_char),
      .next_pos  (next_pos),
      .matched   (step_matched)
   );

   // Input is taken whenever the result slot is free or is being emptied.
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;

   // Next tracker state and result slot.
   always_comb begin
      active_in      = active_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_matched_in = rsp_matched_ff;
      if (req_fire) begin
         if (req_kind == KIND_END) begin
            active_in      = (N + 1)'(1);
            rsp_valid_in   = 1'b1;
            rsp_matched_in = step_matched;
         end else begin
            active_in = next_pos;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= (N + 1)'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_matched_ff <= rsp_matched_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_matched = rsp_matched_ff;

endmodule

// ----- rtl/gwm_cfg.sv -----
module gwm_cfg #(
   parameter int PATTERN_CHARS = 32
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_valid,
   input  gwm_pkg::csr_idx_type                  csr_index,
   input  logic [gwm_pkg::CSR_DATA_W-1:0]        csr_data,
   output logic [PATTERN_CHARS-1:0][7:0]         pattern,
   output logic [$clog2(PATTERN_CHARS+1)-1:0]    used_len
);
   import gwm_pkg::*;

   localparam int LW = $clog2(PATTERN_CHARS + 1);

   logic [PATTERN_CHARS-1:0][7:0] pat_ff;
   logic [LENGTH_W-1:0]           len_ff;

   // Pattern bytes: each character sits in a fixed byte of one word register.
   for (genvar i = 0; i < PATTERN_CHARS; i++) begin : g_char
      always_ff @(posedge clock) begin
         if (reset) begin
            pat_ff[i] <= '0;
         end else if (csr_valid && csr_index == CSR_WORD_IDX[i / CHARS_PER_W]) begin
            pat_ff[i] <= csr_data[(i % CHARS_PER_W) * 8 +: 8];
         end
      end
   end

   // Pattern length register keeps the low six bits as written.
   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= '0;
      end else if (csr_valid && csr_index == CSR_LENGTH) begin
         len_ff <= csr_data[LENGTH_W-1:0];
      end
   end

   // A length above the pattern capacity is taken as the full capacity.
   always_comb begin
      if (len_ff > LENGTH_W'(PATTERN_CHARS)) begin
         used_len = LW'(PATTERN_CHARS);
      end else begin
         used_len = len_ff[LW-1:0];
      end
   end

   assign pattern = pat_ff;

endmodule

// ----- rtl/gwm_step.sv -----
module gwm_step #(
   parameter int PATTERN_CHARS = 32
) (
   input  logic [PATTERN_CHARS:0]                cur_raw,
   input  logic [PATTERN_CHARS-1:0][7:0]         pattern,
   input  logic [$clog2(PATTERN_CHARS+1)-1:0]    used_len,
   input  logic [7:0]                            text_char,
   output logic [PATTERN_CHARS:0]                next_pos,
   output logic                                  matched
);
   import gwm_pkg::*;

   localparam int N    = PATTERN_CHARS;
   localparam int LW   = $clog2(N + 1);
   localparam int LVLS = $clog2(N + 1);

   logic [N-1:0] is_run;
   logic [N-1:0] adv;
   logic [7:0]   text_fold;
   logic [N:0]   gen_v;
   logic [N:0]   prop_v;
   logic [N:0]   cur;

   // Decode each pattern position against the current text byte.
   always_comb begin
      text_fold = fold_char(text_char);
      for (int i = 0; i < N; i++) begin
         is_run[i] = (LW'(i) < used_len) && (pattern[i] == WILD_RUN);
         adv[i]    = (LW'(i) < used_len) && (pattern[i] != WILD_RUN)
                     && ((pattern[i] == WILD_ONE) || (fold_char(pattern[i]) == text_fold));
      end
   end

   // Star closure as a log-depth prefix: an active position followed by a run
   // of stars activates every position up to the end of that run.
   always_comb begin
      logic [N:0] g_prev;
      logic [N:0] p_prev;
      for (int j = 0; j <= N; j++) begin
         gen_v[j]  = cur_raw[j] && (LW'(j) <= used_len);
         prop_v[j] = (j > 0) ? is_run[(j > 0) ? j - 1 : 0] : 1'b0;
      end
      for (int lv = 0; lv < LVLS; lv++) begin
         g_prev = gen_v;
         p_prev = prop_v;
         for (int j = 0; j <= N; j++) begin
            if (j >= (1 << lv)) begin
               gen_v[j]  = g_prev[j] | (p_prev[j] & g_prev[j - (1 << lv)]);
               prop_v[j] = p_prev[j] & p_prev[j - (1 << lv)];
            end
         end
      end
      cur = gen_v;
   end

   // One text character: stars hold their position, other matches advance.
   always_comb begin
      next_pos = '0;
      for (int i = 0; i < N; i++) begin
         if (cur[i] && is_run[i]) begin
            next_pos[i] = 1'b1;
         end
         if (cur[i] && adv[i]) begin
            next_pos[i+1] = 1'b1;
         end
      end
   end

   assign matched = cur[used_len];

endmodule

// ----- rtl/gwm_checker.sv -----
module gwm_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic req_kind,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_matched
);
   import gwm_pkg::*;

   // No result is pending right after reset.
   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result pending after reset");

   // A new result only follows an accepted end-of-string transaction.
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready && (req_kind == KIND_END)))
      else $error("result without end-of-string transaction");

   // A text transaction into an emptying slot leaves no result behind.
   a_text_silent: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && (req_kind == KIND_TEXT) && (!rsp_valid || rsp_ready))
      |=> !rsp_valid)
      else $error("text transaction produced a result");

   // Input is never stalled while the result slot is empty.
   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled with empty result slot");

   // A stalled result holds its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_matched)))
      else $error("stalled result changed");

endmodule

bind glob_wildcard_matcher_top gwm_checker u_gwm_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_ready   (req_ready),
   .req_kind    (req_kind),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_matched (rsp_matched)
);
